### design/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants for polygon area / centroid
// Field widths, status codes and the command / status bundles that join the
// sequencer to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pac_pkg;

    // field and accumulator widths
    localparam int COORD_W  = 16;               // Q8.8 coordinate
    localparam int CROSS_W  = 43;               // shoelace cross sum, wraps
    localparam int MOMENT_W = 61;               // moment sums, wrap
    localparam int PROD_W   = 2 * COORD_W;      // one coordinate product
    localparam int EDGE_W   = PROD_W + 1;       // cross term of one edge
    localparam int PAIR_W   = COORD_W + 1;      // sum of two coordinates
    localparam int MPROD_W  = PAIR_W + EDGE_W;  // moment term of one edge
    localparam int DEN_W    = CROSS_W + 2;      // three times the cross sum
    localparam int QUOT_W   = COORD_W + 1;      // quotient, top bit flags saturation
    localparam int STEP_W   = $clog2(QUOT_W);
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 2'd2;

    // commands from the sequencer
    typedef struct packed {
        logic in_load;      // capture the incoming vertex
        logic set_first;    // first vertex of a polygon
        logic edge_start;   // cross term of edge (prev, vertex)
        logic edge_close;   // cross term of closing edge (prev, first)
        logic mul;          // moment products, cross sum update
        logic acc;          // moment sum update
        logic set_ovf;      // drop vertex, mark too many vertices
        logic den;          // form divisor magnitude and sign
        logic div_init;     // load divider
        logic div_sel_y;    // divider works on y moment
        logic div_step;     // one restoring step
        logic store_x;      // keep saturated x quotient
        logic store_y;      // keep saturated y quotient
        logic out_load;     // load output register, clear accumulators
    } pac_cmd_t;

    // status back to the sequencer
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic ovf;
        logic last;
        logic cross_zero;
        logic out_free;
    } pac_stat_t;

endpackage

`default_nettype wire

### design/pac_div.sv
// ----------------------------------------------------------------------------
// pac_div: restoring divider, one quotient bit per cycle while step is high
// Divides an unsigned moment magnitude by the divisor magnitude shifted up by
// QUOT_W-1, so the quotient comes out in QUOT_W bits; a set top bit means the
// true quotient is out of coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_div (
    input  wire                           aclk,
    input  wire                           init,
    input  wire                           step,
    input  wire  [pac_pkg::MOMENT_W-1:0]  num,
    input  wire  [pac_pkg::DEN_W-1:0]     den,
    output logic [pac_pkg::QUOT_W-1:0]    quot
);
    import pac_pkg::*;

    logic [MOMENT_W-1:0] rem_reg, rem_next;
    logic [MOMENT_W-1:0] dvs_reg, dvs_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [MOMENT_W:0]   diff;

    // trial subtract and shift
    always_comb begin
        diff      = {1'b0, rem_reg} - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (init) begin
            rem_next  = num;
            dvs_next  = {den, {(QUOT_W-1){1'b0}}};
            quot_next = '0;
        end else if (step) begin
            if (!diff[MOMENT_W]) begin
                rem_next  = diff[MOMENT_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end else begin
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            dvs_next = {1'b0, dvs_reg[MOMENT_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

### design/pac_datapath.sv
// ----------------------------------------------------------------------------
// pac_datapath: vertex registers, shoelace accumulators, divider, output word
// Works on commands from the sequencer; holds the output register and its
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_datapath #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  pac_pkg::pac_cmd_t              cmd,
    output pac_pkg::pac_stat_t             stat,
    input  wire  [2*pac_pkg::COORD_W-1:0]  in_data,
    input  wire                            in_last,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [pac_pkg::CROSS_W-1:0]    out_area,
    output logic [pac_pkg::COORD_W-1:0]    out_cx,
    output logic [pac_pkg::COORD_W-1:0]    out_cy,
    output logic [pac_pkg::STATUS_W-1:0]   out_status
);
    import pac_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // vertex registers
    logic signed [COORD_W-1:0] vx_reg, vy_reg;
    logic                      last_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;

    // edge pipeline
    logic signed [EDGE_W-1:0]  c_reg;
    logic signed [PAIR_W-1:0]  sx_reg, sy_reg;
    logic signed [MPROD_W-1:0] mx_reg, my_reg;

    // accumulators
    logic [CROSS_W-1:0]  cross_reg;
    logic [MOMENT_W-1:0] mom_x_reg, mom_y_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ovf_reg;

    // division
    logic [DEN_W-1:0]    den_mag_reg;
    logic                den_neg_reg;
    logic                quot_neg_reg;
    logic [COORD_W-1:0]  cx_reg, cy_reg;

    // output word
    logic                out_valid_reg;
    logic [CROSS_W-1:0]  area_reg;
    logic [COORD_W-1:0]  ocx_reg, ocy_reg;
    logic [STATUS_W-1:0] ostat_reg;

    logic signed [COORD_W-1:0]  qx, qy;
    logic signed [PROD_W-1:0]   p_xy, p_yx;
    logic signed [DEN_W-1:0]    den3;
    logic [MOMENT_W-1:0]        mom_sel;
    logic [MOMENT_W-1:0]        num_mag;
    logic [QUOT_W-1:0]          quot;
    logic [COORD_W-1:0]         sat_q;

    // saturate a quotient magnitude and apply its sign
    function automatic logic [COORD_W-1:0] sat_quot(input logic [QUOT_W-1:0] q,
                                                     input logic neg);
        logic [QUOT_W-1:0] lim;
        logic [QUOT_W-1:0] val;
        begin
            lim = QUOT_W'(1) << (COORD_W - 1);
            if (neg) begin
                val = (q > lim) ? lim : q;
                val = QUOT_W'(0) - val;
            end else begin
                val = (q > lim - QUOT_W'(1)) ? lim - QUOT_W'(1) : q;
            end
            sat_quot = val[COORD_W-1:0];
        end
    endfunction

    // edge end point: incoming vertex or the first one when closing
    assign qx   = cmd.edge_close ? first_x_reg : vx_reg;
    assign qy   = cmd.edge_close ? first_y_reg : vy_reg;
    assign p_xy = prev_x_reg * qy;
    assign p_yx = prev_y_reg * qx;

    // divisor is three times the cross sum
    assign den3 = DEN_W'($signed(cross_reg)) + (DEN_W'($signed(cross_reg)) <<< 1);

    // numerator magnitude
    assign mom_sel = cmd.div_sel_y ? mom_y_reg : mom_x_reg;
    assign num_mag = mom_sel[MOMENT_W-1] ? MOMENT_W'(0) - mom_sel : mom_sel;

    assign sat_q = sat_quot(quot, quot_neg_reg);

    pac_div u_div (
        .aclk (aclk),
        .init (cmd.div_init),
        .step (cmd.div_step),
        .num  (num_mag),
        .den  (den_mag_reg),
        .quot (quot)
    );

    // vertex capture and edge pipeline payload
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            vx_reg   <= in_data[COORD_W-1:0];
            vy_reg   <= in_data[2*COORD_W-1:COORD_W];
            last_reg <= in_last;
        end
        if (cmd.set_first) begin
            first_x_reg <= vx_reg;
            first_y_reg <= vy_reg;
            prev_x_reg  <= vx_reg;
            prev_y_reg  <= vy_reg;
        end
        if (cmd.edge_start) begin
            prev_x_reg <= vx_reg;
            prev_y_reg <= vy_reg;
        end
        if (cmd.edge_start || cmd.edge_close) begin
            c_reg  <= EDGE_W'(p_xy) - EDGE_W'(p_yx);
            sx_reg <= PAIR_W'(prev_x_reg) + PAIR_W'(qx);
            sy_reg <= PAIR_W'(prev_y_reg) + PAIR_W'(qy);
        end
        if (cmd.mul) begin
            mx_reg <= sx_reg * c_reg;
            my_reg <= sy_reg * c_reg;
        end
        if (cmd.den) begin
            den_neg_reg <= den3[DEN_W-1];
            den_mag_reg <= den3[DEN_W-1] ? DEN_W'(0) - den3 : den3;
        end
        if (cmd.div_init) begin
            quot_neg_reg <= mom_sel[MOMENT_W-1] ^ den_neg_reg;
        end
        if (cmd.store_x) begin
            cx_reg <= sat_q;
        end
        if (cmd.store_y) begin
            cy_reg <= sat_q;
        end
    end

    // accumulators and vertex count
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            cross_reg <= '0;
            mom_x_reg <= '0;
            mom_y_reg <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.set_first || cmd.edge_start) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.mul) begin
                cross_reg <= cross_reg + CROSS_W'(c_reg);
            end
            if (cmd.acc) begin
                mom_x_reg <= mom_x_reg + MOMENT_W'(mx_reg);
                mom_y_reg <= mom_y_reg + MOMENT_W'(my_reg);
            end
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (ovf_reg) begin
                area_reg  <= '0;
                ocx_reg   <= '0;
                ocy_reg   <= '0;
                ostat_reg <= STATUS_OVERFLOW;
            end else if (cross_reg == '0) begin
                area_reg  <= cross_reg;
                ocx_reg   <= '0;
                ocy_reg   <= '0;
                ostat_reg <= STATUS_DEGENERATE;
            end else begin
                area_reg  <= cross_reg;
                ocx_reg   <= cx_reg;
                ocy_reg   <= cy_reg;
                ostat_reg <= STATUS_OK;
            end
        end
    end

    // status to sequencer
    always_comb begin
        stat.cnt_zero   = (cnt_reg == '0);
        stat.cnt_full   = (cnt_reg == CNT_W'(MAX_VERTICES));
        stat.ovf        = ovf_reg;
        stat.last       = last_reg;
        stat.cross_zero = (cross_reg == '0);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_area   = area_reg;
    assign out_cx     = ocx_reg;
    assign out_cy     = ocy_reg;
    assign out_status = ostat_reg;

endmodule

`default_nettype wire

### design/pac_ctrl.sv
// ----------------------------------------------------------------------------
// pac_ctrl: sequencer for polygon area / centroid
// Steps each vertex through the edge stages, closes the ring on the last
// vertex, runs the two divisions and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  pac_pkg::pac_stat_t  stat,
    output pac_pkg::pac_cmd_t   cmd
);
    import pac_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_VERT   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_ACC    = 4'd3;
    localparam logic [3:0] ST_CLOSE  = 4'd4;
    localparam logic [3:0] ST_DEN    = 4'd5;
    localparam logic [3:0] ST_DINIT  = 4'd6;
    localparam logic [3:0] ST_DSTEP  = 4'd7;
    localparam logic [3:0] ST_DSTORE = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic              closing_reg, closing_next;
    logic              div_y_reg, div_y_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        closing_next = closing_reg;
        div_y_next   = div_y_reg;
        step_next    = step_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
                if (in_valid) begin
                    state_next = ST_VERT;
                end
            end
            ST_VERT: begin
                if (stat.cnt_zero) begin
                    cmd.set_first = 1'b1;
                    state_next    = stat.last ? ST_CLOSE : ST_IDLE;
                end else if (!stat.cnt_full) begin
                    cmd.edge_start = 1'b1;
                    state_next     = ST_MUL;
                end else begin
                    cmd.set_ovf = 1'b1;
                    state_next  = stat.last ? ST_OUT : ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (closing_reg) begin
                    state_next = ST_DEN;
                end else if (stat.last) begin
                    state_next = ST_CLOSE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE: begin
                cmd.edge_close = 1'b1;
                closing_next   = 1'b1;
                state_next     = ST_MUL;
            end
            ST_DEN: begin
                cmd.den    = 1'b1;
                div_y_next = 1'b0;
                state_next = stat.cross_zero ? ST_OUT : ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init  = 1'b1;
                cmd.div_sel_y = div_y_reg;
                step_next     = STEP_W'(QUOT_W - 1);
                state_next    = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_DSTORE;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DSTORE: begin
                if (div_y_reg) begin
                    cmd.store_y = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    cmd.store_x = 1'b1;
                    div_y_next  = 1'b1;
                    state_next  = ST_DINIT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    closing_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            closing_reg <= 1'b0;
            div_y_reg   <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            div_y_reg   <= div_y_next;
            step_reg    <= step_next;
        end
    end

endmodule

`default_nettype wire

### design/polygon_area_centroid_top.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid_top: shoelace area and centroid of a vertex stream
// Accumulates cross and moment sums per polygon, closes the ring on the last
// vertex and divides the moments by three times the cross sum.
//
//   port group  dir  tdata / tuser (lowest bit up)                 tlast
//   s_          in   tdata: vertex_x[15:0], vertex_y[31:16]        last_vertex
//   m_          out  tdata: area[42:0], centroid_x[58:43],
//                    centroid_y[74:59], zero pad; tuser: status    -
//
// A vertex that is not last passes accept, cross products, moment products and
// moment accumulate; the first of a polygon passes only accept and first-vertex
// capture. The last vertex adds the closing edge, divisor set-up and two 17-step
// restoring divisions in one shared divider, each with its load and store step,
// then the load of the output word.
// A zero cross sum or a dropped vertex skips the divisions.
// The output word is registered; a stalled m_ side only holds the block in
// its final cycle. Synchronous active-low reset clears all accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_centroid_top #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,    // vertex_x, vertex_y
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,    // area, centroid_x, centroid_y, zero pad
    output logic [1:0]  m_tuser     // status
);
    import pac_pkg::*;

    pac_cmd_t            cmd;
    pac_stat_t           stat;
    logic [CROSS_W-1:0]  area;
    logic [COORD_W-1:0]  cx, cy;
    logic [STATUS_W-1:0] status;

    // sequencer
    pac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and output register
    pac_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_area   (area),
        .out_cx     (cx),
        .out_cy     (cy),
        .out_status (status)
    );

    // pack the result word
    assign m_tdata = {5'b0, cy, cx, area};
    assign m_tuser = status;

endmodule

`default_nettype wire

### tb/sv/pac_checker.sv
// ----------------------------------------------------------------------------
// pac_checker: result predictor and scoreboard for polygon_area_centroid_top
// Watches both stream channels. Every accepted vertex word is run through a
// shoelace predictor (cross sum, moment sums, closing edge, saturated
// centroid divide), and each polygon result word is compared field by field
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module pac_checker #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [31:0] s_tdata,    // vertex_x, vertex_y
    input  wire         s_tlast,    // last_vertex
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [79:0] m_tdata,    // area, centroid_x, centroid_y, zero pad
    input  wire  [1:0]  m_tuser,    // status
    output int          errors,
    output int          outstanding,
    output int          results_checked
);
    import pac_pkg::*;

    typedef struct packed {
        logic [CROSS_W-1:0]  area;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [STATUS_W-1:0] status;
    } polygon_result_t;

    // predictor state for the polygon being collected
    logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
    logic [CROSS_W-1:0]        cross_sum;
    logic [MOMENT_W-1:0]       moment_x, moment_y;
    int unsigned               held_vertices;
    bit                        too_many;

    polygon_result_t expected_polygons[$];
    int error_count = 0;
    int checked_count = 0;

    assign errors          = error_count;
    assign results_checked = checked_count;

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void clear_polygon();
        first_x       = '0;
        first_y       = '0;
        prev_x        = '0;
        prev_y        = '0;
        cross_sum     = '0;
        moment_x      = '0;
        moment_y      = '0;
        held_vertices = 0;
        too_many      = 1'b0;
    endfunction

    // edge (p, q): twice the signed triangle area and its two moment terms
    function automatic void add_edge(input logic signed [COORD_W-1:0] px, py, qx, qy);
        longint     tri2;
        logic [63:0] term;
        tri2      = longint'(px) * longint'(qy) - longint'(py) * longint'(qx);
        term      = tri2;
        cross_sum = cross_sum + term[CROSS_W-1:0];
        term      = (longint'(px) + longint'(qx)) * tri2;
        moment_x  = moment_x + term[MOMENT_W-1:0];
        term      = (longint'(py) + longint'(qy)) * tri2;
        moment_y  = moment_y + term[MOMENT_W-1:0];
    endfunction

    // moment / (3 * cross sum), truncated toward zero, saturated to Q8.8
    function automatic logic [COORD_W-1:0] centroid_q88(input logic [MOMENT_W-1:0] msum,
                                                        input longint area2);
        longint      num, den;
        logic [63:0] num_mag, den_mag, quo, lim;
        bit          neg;
        num     = longint'($signed(msum));
        den     = 3 * area2;
        num_mag = (num < 0) ? -num : num;
        den_mag = (den < 0) ? -den : den;
        neg     = (num < 0) != (den < 0);
        quo     = num_mag / den_mag;
        lim     = 64'd1 << (COORD_W - 1);
        if (neg) begin
            if (quo > lim)
                quo = lim;
            quo = -quo;
        end else if (quo > lim - 1) begin
            quo = lim - 1;
        end
        return quo[COORD_W-1:0];
    endfunction

    // one vertex in; returns 1 with the polygon result when it closes the ring
    function automatic bit take_vertex(input logic signed [COORD_W-1:0] vx, vy,
                                       input bit last, output polygon_result_t res);
        longint area2;
        res = '0;
        if (held_vertices == 0) begin
            first_x       = vx;
            first_y       = vy;
            prev_x        = vx;
            prev_y        = vy;
            held_vertices = 1;
        end else if (held_vertices < MAX_VERTICES) begin
            add_edge(prev_x, prev_y, vx, vy);
            prev_x = vx;
            prev_y = vy;
            held_vertices++;
        end else begin
            // vertex past the limit is dropped
            too_many = 1'b1;
        end
        if (!last)
            return 1'b0;
        if (too_many) begin
            res.status = STATUS_OVERFLOW;
        end else begin
            add_edge(prev_x, prev_y, first_x, first_y);
            area2    = longint'($signed(cross_sum));
            res.area = cross_sum;
            if (area2 == 0) begin
                res.status = STATUS_DEGENERATE;
            end else begin
                res.cx     = centroid_q88(moment_x, area2);
                res.cy     = centroid_q88(moment_y, area2);
                res.status = STATUS_OK;
            end
        end
        clear_polygon();
        return 1'b1;
    endfunction

    // compare result words, then predict from vertex words
    always @(posedge aclk) begin : watch
        polygon_result_t got, want, fresh;
        if (!aresetn) begin
            clear_polygon();
            expected_polygons.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.area   = m_tdata[CROSS_W-1:0];
                got.cx     = m_tdata[CROSS_W +: COORD_W];
                got.cy     = m_tdata[CROSS_W+COORD_W +: COORD_W];
                got.status = m_tuser;
                if (expected_polygons.size() == 0) begin
                    flag_error($sformatf("result word with nothing expected: area %h status %0d",
                                         got.area, got.status));
                end else begin
                    want = expected_polygons.pop_front();
                    checked_count++;
                    if (got.area !== want.area)
                        flag_error($sformatf("area got %h want %h", got.area, want.area));
                    if (got.cx !== want.cx)
                        flag_error($sformatf("centroid_x got %h want %h", got.cx, want.cx));
                    if (got.cy !== want.cy)
                        flag_error($sformatf("centroid_y got %h want %h", got.cy, want.cy));
                    if (got.status !== want.status)
                        flag_error($sformatf("status got %0d want %0d", got.status, want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                if (take_vertex($signed(s_tdata[15:0]), $signed(s_tdata[31:16]), s_tlast, fresh))
                    expected_polygons.push_back(fresh);
            end
        end
        outstanding <= expected_polygons.size();
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for polygon_area_centroid_top
// Sends directed polygons (single and two vertex rings, collinear rings,
// extreme corners, both orientations, a near-cancelling bowtie), then random
// polygons of mixed shape and size.
// The sender idles in random bursts, the receiver stalls on its own pattern
// with one long hold-off; pac_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VERTEX_LIMIT    = 1024;
    localparam int ITEM_TARGET     = 850;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 600000;

    // polygon shapes for the random part
    localparam int SHAPE_WIDE    = 0;   // full-range coordinates
    localparam int SHAPE_LOCAL   = 1;   // clustered, with repeated vertices
    localparam int SHAPE_CORNERS = 2;   // coordinates near the range ends
    localparam int SHAPE_LINE    = 3;   // collinear ring, zero area

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // vertex_x, vertex_y
    logic        s_tlast;       // last_vertex
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;       // area, centroid_x, centroid_y, zero pad
    logic [1:0]  m_tuser;       // status
    logic        long_hold_req;

    int errors;
    int outstanding;
    int results_checked;
    int cycle_count   = 0;
    int burst_left    = 0;
    int vertices_sent = 0;
    int polygons_sent = 0;
    bit gaps_on       = 1'b1;

    polygon_area_centroid_top #(
        .MAX_VERTICES (VERTEX_LIMIT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pac_checker #(
        .MAX_VERTICES (VERTEX_LIMIT)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // clock and cycle count
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // run limit
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
        $display("FAIL polygon_area_centroid_top");
        $finish;
    end

    // receiver stall pattern, plus one long hold-off on request
    initial begin : ready_pattern
        int mode, mode_left, hold_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one vertex word, with a random gap at the start of each burst
    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        vertices_sent++;
    endtask

    // sender pause until every predicted result has come out
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] corner_coord();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_polygon(input int n, input int shape);
        logic [15:0] x, y, base_x, base_y, step_x, step_y;
        int k;
        base_x = 16'($urandom);
        base_y = 16'($urandom);
        step_x = 16'($urandom_range(0, 200)) - 16'd100;
        step_y = 16'($urandom_range(0, 200)) - 16'd100;
        // keep collinear rings clear of coordinate wrap
        if (shape == SHAPE_LINE) begin
            base_x = 16'($urandom_range(0, 16000)) - 16'd8000;
            base_y = 16'($urandom_range(0, 16000)) - 16'd8000;
        end
        x = base_x;
        y = base_y;
        for (k = 0; k < n; k++) begin
            case (shape)
                SHAPE_WIDE: begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                SHAPE_LOCAL: begin
                    // now and then the previous vertex repeats
                    if ($urandom_range(0, 7) != 0) begin
                        x = base_x + 16'($urandom_range(0, 1023)) - 16'd512;
                        y = base_y + 16'($urandom_range(0, 1023)) - 16'd512;
                    end
                end
                SHAPE_CORNERS: begin
                    x = corner_coord();
                    y = corner_coord();
                end
                default: begin
                    x = 16'(base_x + k * step_x);
                    y = 16'(base_y + k * step_y);
                end
            endcase
            send_vertex(x, y, k == n - 1);
        end
        polygons_sent++;
    endtask

    // mostly small rings, some degenerate stubs, a few long ones
    task automatic random_polygon();
        int pick, n;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            n = $urandom_range(3, 8);
        else if (pick < 85)
            n = $urandom_range(9, 40);
        else if (pick < 95)
            n = $urandom_range(1, 2);
        else
            n = $urandom_range(41, 120);
        if ($urandom_range(0, 9) == 0)
            gaps_on = !gaps_on;
        send_polygon(n, $urandom_range(SHAPE_WIDE, SHAPE_LINE));
    endtask

    // stimulus and verdict
    initial begin
        int k;
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tlast       <= 1'b0;
        long_hold_req <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single vertex and two-vertex rings: zero area
        send_vertex(16'h1234, 16'hFEDC, 1'b1);
        send_vertex(16'h8000, 16'h7FFF, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b1);
        // extreme triangle, counterclockwise then clockwise
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h8000, 16'h8000, 1'b1);
        // collinear ring
        send_vertex(16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h0100, 16'h0100, 1'b0);
        send_vertex(16'h0200, 16'h0200, 1'b1);
        // full-range square
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h8000, 16'h7FFF, 1'b1);
        // bowtie whose halves nearly cancel: centroid saturates
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h8000, 16'h7FFE, 1'b1);
        // smallest triangle, quotient truncation
        send_vertex(16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h0001, 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'h0001, 1'b1);
        polygons_sent += 8;
        wait_all_results();

        // long receiver hold-off while the sender keeps offering
        long_hold_req <= 1'b1;
        gaps_on = 1'b0;
        for (k = 0; k < 8; k++)
            send_polygon($urandom_range(3, 6), SHAPE_WIDE);
        gaps_on = 1'b1;
        while (vertices_sent < ITEM_TARGET / 2)
            random_polygon();
        wait_all_results();

        while (vertices_sent < ITEM_TARGET)
            random_polygon();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d vertices in %0d polygons, %0d results compared", vertices_sent,
                 polygons_sent, results_checked);
        $display("covered stub, collinear, extreme and self-crossing polygons under stalls");
        if (errors == 0 && outstanding == 0) begin
            $display("PASS polygon_area_centroid_top");
        end else begin
            $display("FAIL polygon_area_centroid_top");
        end
        $finish;
    end

endmodule
